[rtl/core/rmb_pkg.sv]
// Shared types and fixed address map constants for the region mapped memory bus.
package rmb_pkg;

  // Region selected by the address decoder, in decode priority order.
  typedef enum logic [2:0] {
    RG_PFLASH,
    RG_DFLASH,
    RG_DSRAM,
    RG_PSRAM,
    RG_UCB,
    RG_XRAM,
    RG_NONE
  } region_t;

  // Access size codes; the fourth code is reserved and refused.
  localparam logic [1:0] SZ_BYTE = 2'd0;
  localparam logic [1:0] SZ_HALF = 2'd1;
  localparam logic [1:0] SZ_WORD = 2'd2;

  // Command codes.
  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // Window bases of the bus address map.
  localparam logic [31:0] PFLASH_BASE   = 32'hA000_0000;
  localparam logic [31:0] PFLASH_MIRROR = 32'h8000_0000;
  localparam logic [31:0] DFLASH_BASE   = 32'hAF00_0000;
  localparam logic [31:0] DSRAM_BASE    = 32'h7000_0000;
  localparam logic [31:0] DSRAM_MIRROR  = 32'hD000_0000;
  localparam logic [31:0] PSRAM_BASE    = 32'h7010_0000;
  localparam logic [31:0] PSRAM_MIRROR  = 32'hC000_0000;
  localparam logic [31:0] UCB_BASE      = 32'hAF40_0000;
  localparam logic [31:0] XRAM_BASE     = 32'hF024_0000;

endpackage

[rtl/core/region_mapped_memory_bus_unit.sv]
// Region mapped memory bus: address decode, six regions packed into two byte-lane RAM banks.
//
// One access (read or write of 1, 2 or 4 bytes, any alignment) is taken per clock whenever
// busy is low. Its result passes the capture, decode and bank issue stages and is driven on
// strobe, read_data and access_error from registers at the end of stage 3. Results leave in order
// and the receiver cannot stall them, so the unit never pushes back during normal operation.
// All six regions live in one
// unified byte space, each region starting on a 4-byte row, and that space is split into an
// even-row bank and an odd-row bank, both single-port synchronous RAMs with byte enables and
// a registered read. Any access of up to four bytes touches at most two adjacent rows, one in
// each bank, so each bank sees one access per beat and that single port sets the rate of one
// beat per cycle. A write lands at the end of the issue stage before the next beat reads,
// so back-to-back accesses to the same bytes need no forwarding. Unmapped addresses,
// accesses running past the end of their region and the reserved size code return
// access_error with read_data zero and change nothing; writes always return read_data zero.
// After reset the unit runs a clearing pass that zeroes one row pair per cycle and holds busy
// high until all BANK_DEPTH = TOTAL_BYTES/8 + 1 row pairs are cleared (308225 with the defaults).
module region_mapped_memory_bus_unit #(
  parameter int unsigned PFLASH_BYTES = 2097152,
  parameter int unsigned DFLASH_BYTES = 131072,
  parameter int unsigned DSRAM_BYTES  = 196608,
  parameter int unsigned PSRAM_BYTES  = 8192,
  parameter int unsigned UCB_BYTES    = 24576,
  parameter int unsigned XRAM_BYTES   = 8192
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        cmd,
  input  logic [1:0]  size_code,
  input  logic [31:0] address,
  input  logic [31:0] write_data,
  output logic        strobe,
  output logic [31:0] read_data,
  output logic        access_error
);

  // Largest region sets the width of a region offset.
  localparam int unsigned MAX_A = (PFLASH_BYTES > DFLASH_BYTES) ? PFLASH_BYTES : DFLASH_BYTES;
  localparam int unsigned MAX_B = (DSRAM_BYTES > PSRAM_BYTES) ? DSRAM_BYTES : PSRAM_BYTES;
  localparam int unsigned MAX_C = (UCB_BYTES > XRAM_BYTES) ? UCB_BYTES : XRAM_BYTES;
  localparam int unsigned MAX_AB = (MAX_A > MAX_B) ? MAX_A : MAX_B;
  localparam int unsigned MAX_BYTES = (MAX_AB > MAX_C) ? MAX_AB : MAX_C;
  localparam int unsigned OFF_W = $clog2(MAX_BYTES + 1);

  // Each region starts on a 4-byte row of the unified space.
  localparam int unsigned PF_RND = (PFLASH_BYTES + 3) / 4 * 4;
  localparam int unsigned DF_RND = (DFLASH_BYTES + 3) / 4 * 4;
  localparam int unsigned DS_RND = (DSRAM_BYTES + 3) / 4 * 4;
  localparam int unsigned PS_RND = (PSRAM_BYTES + 3) / 4 * 4;
  localparam int unsigned UC_RND = (UCB_BYTES + 3) / 4 * 4;
  localparam int unsigned XR_RND = (XRAM_BYTES + 3) / 4 * 4;

  localparam int unsigned UB_PF = 0;
  localparam int unsigned UB_DF = UB_PF + PF_RND;
  localparam int unsigned UB_DS = UB_DF + DF_RND;
  localparam int unsigned UB_PS = UB_DS + DS_RND;
  localparam int unsigned UB_UC = UB_PS + PS_RND;
  localparam int unsigned UB_XR = UB_UC + UC_RND;
  localparam int unsigned TOTAL_BYTES = UB_XR + XR_RND;

  // Two banks of rows, even and odd, plus one spare row pair for the unused half of an
  // access that stays within its last row.
  localparam int unsigned TOTAL_ROWS = TOTAL_BYTES / 4;
  localparam int unsigned BANK_DEPTH = TOTAL_ROWS / 2 + 1;
  localparam int unsigned BANK_AW = $clog2(BANK_DEPTH);
  localparam int unsigned UA_W = $clog2(TOTAL_BYTES + 8);

  // ---------------------------------------------------------------------------------------
  // Clearing pass after reset
  // ---------------------------------------------------------------------------------------
  logic               clearing;
  logic [BANK_AW-1:0] clr_idx;
  logic               accept;

  assign busy   = clearing;
  assign accept = start && !clearing;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx  <= '0;
    end else if (clearing) begin
      // Advance one row pair a cycle; drop busy after the last pair.
      if (clr_idx == BANK_AW'(BANK_DEPTH - 1)) begin
        clearing <= 1'b0;
      end
      clr_idx <= clr_idx + 1'b1;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stage 0: capture the accepted beat
  // ---------------------------------------------------------------------------------------
  logic        p0_valid;
  logic        p0_cmd;
  logic [1:0]  p0_size;
  logic [31:0] p0_addr;
  logic [31:0] p0_wdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      p0_valid <= 1'b0;
    end else begin
      p0_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p0_cmd   <= cmd;
      p0_size  <= size_code;
      p0_addr  <= address;
      p0_wdata <= write_data;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stage 1: window decode. All nine window compares run in parallel; the first hit in the
  // fixed priority order picks the region and its offset.
  // ---------------------------------------------------------------------------------------
  logic [32:0] d_pf, d_pfm, d_df, d_ds, d_dsm, d_ps, d_psm, d_uc, d_xr;
  logic        h_pf, h_pfm, h_df, h_ds, h_dsm, h_ps, h_psm, h_uc, h_xr;
  rmb_pkg::region_t dec_region;
  logic [OFF_W-1:0] dec_off;

  assign d_pf  = {1'b0, p0_addr} - {1'b0, rmb_pkg::PFLASH_BASE};
  assign d_pfm = {1'b0, p0_addr} - {1'b0, rmb_pkg::PFLASH_MIRROR};
  assign d_df  = {1'b0, p0_addr} - {1'b0, rmb_pkg::DFLASH_BASE};
  assign d_ds  = {1'b0, p0_addr} - {1'b0, rmb_pkg::DSRAM_BASE};
  assign d_dsm = {1'b0, p0_addr} - {1'b0, rmb_pkg::DSRAM_MIRROR};
  assign d_ps  = {1'b0, p0_addr} - {1'b0, rmb_pkg::PSRAM_BASE};
  assign d_psm = {1'b0, p0_addr} - {1'b0, rmb_pkg::PSRAM_MIRROR};
  assign d_uc  = {1'b0, p0_addr} - {1'b0, rmb_pkg::UCB_BASE};
  assign d_xr  = {1'b0, p0_addr} - {1'b0, rmb_pkg::XRAM_BASE};

  // A borrow out means the address lies below the window base.
  assign h_pf  = !d_pf[32]  && (d_pf[31:0]  < 32'(PFLASH_BYTES));
  assign h_pfm = !d_pfm[32] && (d_pfm[31:0] < 32'(PFLASH_BYTES));
  assign h_df  = !d_df[32]  && (d_df[31:0]  < 32'(DFLASH_BYTES));
  assign h_ds  = !d_ds[32]  && (d_ds[31:0]  < 32'(DSRAM_BYTES));
  assign h_dsm = !d_dsm[32] && (d_dsm[31:0] < 32'(DSRAM_BYTES));
  assign h_ps  = !d_ps[32]  && (d_ps[31:0]  < 32'(PSRAM_BYTES));
  assign h_psm = !d_psm[32] && (d_psm[31:0] < 32'(PSRAM_BYTES));
  assign h_uc  = !d_uc[32]  && (d_uc[31:0]  < 32'(UCB_BYTES));
  assign h_xr  = !d_xr[32]  && (d_xr[31:0]  < 32'(XRAM_BYTES));

  always_comb begin
    dec_region = rmb_pkg::RG_NONE;
    dec_off    = '0;
    if (h_pf) begin
      dec_region = rmb_pkg::RG_PFLASH;
      dec_off    = d_pf[OFF_W-1:0];
    end else if (h_pfm) begin
      dec_region = rmb_pkg::RG_PFLASH;
      dec_off    = d_pfm[OFF_W-1:0];
    end else if (h_df) begin
      dec_region = rmb_pkg::RG_DFLASH;
      dec_off    = d_df[OFF_W-1:0];
    end else if (h_ds) begin
      dec_region = rmb_pkg::RG_DSRAM;
      dec_off    = d_ds[OFF_W-1:0];
    end else if (h_dsm) begin
      dec_region = rmb_pkg::RG_DSRAM;
      dec_off    = d_dsm[OFF_W-1:0];
    end else if (h_ps) begin
      dec_region = rmb_pkg::RG_PSRAM;
      dec_off    = d_ps[OFF_W-1:0];
    end else if (h_psm) begin
      dec_region = rmb_pkg::RG_PSRAM;
      dec_off    = d_psm[OFF_W-1:0];
    end else if (h_uc) begin
      dec_region = rmb_pkg::RG_UCB;
      dec_off    = d_uc[OFF_W-1:0];
    end else if (h_xr) begin
      dec_region = rmb_pkg::RG_XRAM;
      dec_off    = d_xr[OFF_W-1:0];
    end
  end

  logic             p1_valid;
  logic             p1_cmd;
  logic [1:0]       p1_size;
  logic [31:0]      p1_wdata;
  rmb_pkg::region_t p1_region;
  logic [OFF_W-1:0] p1_off;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else begin
      p1_valid <= p0_valid;
    end
  end

  always_ff @(posedge clk) begin
    p1_cmd    <= p0_cmd;
    p1_size   <= p0_size;
    p1_wdata  <= p0_wdata;
    p1_region <= dec_region;
    p1_off    <= dec_off;
  end

  // ---------------------------------------------------------------------------------------
  // Stage 2: end-of-region check, unified address, bank issue
  // ---------------------------------------------------------------------------------------
  logic [OFF_W-1:0] reg_size;
  logic [UA_W-1:0]  reg_ub;
  logic [UA_W-1:0]  reg_ub4;
  logic [2:0]       nbytes;
  logic [7:0]       be_base;
  logic             size_bad;
  logic             over_end;
  logic             acc_err;
  logic [UA_W-1:0]  ua;
  logic [UA_W-1:0]  ua4;
  logic [1:0]       lane;
  logic             row_odd;
  logic [7:0]       span_be;
  logic [63:0]      span_wd;
  logic             do_write;
  logic [BANK_AW-1:0] even_idx;
  logic [BANK_AW-1:0] odd_idx;
  logic [3:0]       even_be;
  logic [3:0]       odd_be;
  logic [31:0]      even_wd;
  logic [31:0]      odd_wd;
  logic [BANK_AW-1:0] even_addr;
  logic [BANK_AW-1:0] odd_addr;

  always_comb begin
    reg_size = '0;
    reg_ub   = '0;
    reg_ub4  = '0;
    case (p1_region)
      rmb_pkg::RG_PFLASH: begin
        reg_size = OFF_W'(PFLASH_BYTES);
        reg_ub   = UA_W'(UB_PF);
        reg_ub4  = UA_W'(UB_PF + 4);
      end
      rmb_pkg::RG_DFLASH: begin
        reg_size = OFF_W'(DFLASH_BYTES);
        reg_ub   = UA_W'(UB_DF);
        reg_ub4  = UA_W'(UB_DF + 4);
      end
      rmb_pkg::RG_DSRAM: begin
        reg_size = OFF_W'(DSRAM_BYTES);
        reg_ub   = UA_W'(UB_DS);
        reg_ub4  = UA_W'(UB_DS + 4);
      end
      rmb_pkg::RG_PSRAM: begin
        reg_size = OFF_W'(PSRAM_BYTES);
        reg_ub   = UA_W'(UB_PS);
        reg_ub4  = UA_W'(UB_PS + 4);
      end
      rmb_pkg::RG_UCB: begin
        reg_size = OFF_W'(UCB_BYTES);
        reg_ub   = UA_W'(UB_UC);
        reg_ub4  = UA_W'(UB_UC + 4);
      end
      rmb_pkg::RG_XRAM: begin
        reg_size = OFF_W'(XRAM_BYTES);
        reg_ub   = UA_W'(UB_XR);
        reg_ub4  = UA_W'(UB_XR + 4);
      end
      default: begin
        reg_size = '0;
        reg_ub   = '0;
        reg_ub4  = '0;
      end
    endcase
  end

  always_comb begin
    nbytes   = 3'd0;
    be_base  = 8'h00;
    size_bad = 1'b0;
    case (p1_size)
      rmb_pkg::SZ_BYTE: begin
        nbytes  = 3'd1;
        be_base = 8'h01;
      end
      rmb_pkg::SZ_HALF: begin
        nbytes  = 3'd2;
        be_base = 8'h03;
      end
      rmb_pkg::SZ_WORD: begin
        nbytes  = 3'd4;
        be_base = 8'h0F;
      end
      default: begin
        size_bad = 1'b1;
      end
    endcase
  end

  assign over_end = ({1'b0, p1_off} + (OFF_W + 1)'(nbytes)) > {1'b0, reg_size};
  assign acc_err  = (p1_region == rmb_pkg::RG_NONE) || size_bad || over_end;

  // Row r = ua / 4 sits in bank r[0] at index r / 2; the following row sits in the other
  // bank, which puts the even index at (ua + 4) / 8 and the odd index at ua / 8.
  assign ua       = reg_ub + UA_W'(p1_off);
  assign ua4      = reg_ub4 + UA_W'(p1_off);
  assign lane     = ua[1:0];
  assign row_odd  = ua[2];
  assign odd_idx  = BANK_AW'(ua >> 3);
  assign even_idx = BANK_AW'(ua4 >> 3);

  assign span_be  = be_base << lane;
  assign span_wd  = {32'h0, p1_wdata} << {lane, 3'b000};
  assign do_write = p1_valid && (p1_cmd == rmb_pkg::CMD_WRITE) && !acc_err;

  // Low half of the span belongs to the first row, high half to the next row.
  always_comb begin
    if (clearing) begin
      even_addr = clr_idx;
      odd_addr  = clr_idx;
      even_be   = 4'hF;
      odd_be    = 4'hF;
      even_wd   = '0;
      odd_wd    = '0;
    end else begin
      even_addr = even_idx;
      odd_addr  = odd_idx;
      even_be   = do_write ? (row_odd ? span_be[7:4] : span_be[3:0]) : 4'h0;
      odd_be    = do_write ? (row_odd ? span_be[3:0] : span_be[7:4]) : 4'h0;
      even_wd   = row_odd ? span_wd[63:32] : span_wd[31:0];
      odd_wd    = row_odd ? span_wd[31:0] : span_wd[63:32];
    end
  end

  // Even-row and odd-row banks: one port each, byte write enables, registered read.
  logic [3:0][7:0] even_mem [BANK_DEPTH];
  logic [3:0][7:0] odd_mem  [BANK_DEPTH];
  logic [31:0]     even_rd;
  logic [31:0]     odd_rd;

  always_ff @(posedge clk) begin
    for (int b = 0; b < 4; b++) begin
      if (even_be[b]) begin
        even_mem[even_addr][b] <= even_wd[b*8 +: 8];
      end
    end
    even_rd <= even_mem[even_addr];
  end

  always_ff @(posedge clk) begin
    for (int b = 0; b < 4; b++) begin
      if (odd_be[b]) begin
        odd_mem[odd_addr][b] <= odd_wd[b*8 +: 8];
      end
    end
    odd_rd <= odd_mem[odd_addr];
  end

  logic       p2_valid;
  logic       p2_rd;
  logic       p2_err;
  logic [1:0] p2_lane;
  logic       p2_row_odd;
  logic [1:0] p2_size;

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_valid <= 1'b0;
    end else begin
      p2_valid <= p1_valid;
    end
  end

  always_ff @(posedge clk) begin
    p2_rd      <= (p1_cmd == rmb_pkg::CMD_READ) && !acc_err;
    p2_err     <= acc_err;
    p2_lane    <= lane;
    p2_row_odd <= row_odd;
    p2_size    <= p1_size;
  end

  // ---------------------------------------------------------------------------------------
  // Stage 3: realign the two rows and register the result beat
  // ---------------------------------------------------------------------------------------
  logic [31:0] rd_lo;
  logic [31:0] rd_hi;
  logic [63:0] rd_span;
  logic [31:0] rd_mask;
  logic [31:0] read_data_next;

  assign rd_lo   = p2_row_odd ? odd_rd : even_rd;
  assign rd_hi   = p2_row_odd ? even_rd : odd_rd;
  assign rd_span = {rd_hi, rd_lo} >> {p2_lane, 3'b000};

  always_comb begin
    case (p2_size)
      rmb_pkg::SZ_BYTE: rd_mask = 32'h0000_00FF;
      rmb_pkg::SZ_HALF: rd_mask = 32'h0000_FFFF;
      rmb_pkg::SZ_WORD: rd_mask = 32'hFFFF_FFFF;
      default:          rd_mask = 32'h0000_0000;
    endcase
  end

  // Zero the data for writes and refused beats.
  assign read_data_next = p2_rd ? (rd_span[31:0] & rd_mask) : 32'h0;

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= p2_valid;
    end
  end

  always_ff @(posedge clk) begin
    read_data    <= read_data_next;
    access_error <= p2_err;
  end

  // ---------------------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------------------
  a_result_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##4 strobe)
    else $error("accepted beat did not produce a result four cycles later");

  a_clear_empty_pipe: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !(p0_valid || p1_valid || p2_valid))
    else $error("beat in flight during the clearing pass");

  a_refused_no_write: assert property (@(posedge clk) disable iff (rst)
    (p1_valid && acc_err) |-> (even_be == 4'h0 && odd_be == 4'h0))
    else $error("refused beat wrote to a bank");

  a_write_byte_count: assert property (@(posedge clk) disable iff (rst)
    do_write |-> ($countones({even_be, odd_be}) == int'(nbytes)))
    else $error("write enables do not match the access size");

endmodule
